// ===== rtl/fitch_parsimony_down_pass_assert.svh =====
// Assertion macros for the Fitch down-pass block.
// Included by the top level; needs nothing else.
`ifndef FITCH_PARSIMONY_DOWN_PASS_ASSERT_SVH
`define FITCH_PARSIMONY_DOWN_PASS_ASSERT_SVH
`ifndef ASSERT_OFF
`define FPDP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FPDP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define FPDP_ASSERT(lbl, clk, rstn, prop, msg)
`define FPDP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/fpdp_pkg.sv =====
// Shared types, constants and helpers for the Fitch down-pass block.
// No dependencies.
`default_nettype none
package fpdp_pkg;

  localparam int NODES_DEF = 256;
  localparam int CHARS_DEF = 256;
  localparam int LANES_DEF = 16;

  localparam int MASK_W   = 8;
  localparam int WEIGHT_W = 8;
  localparam int CNT_W    = 9;
  localparam int CFG_W    = 9;
  localparam int PROD_W   = CNT_W + WEIGHT_W;
  localparam int GRP_LANES = 8;
  localparam int GRP_W    = 20;
  localparam int LEN_W    = 24;

  localparam logic [CNT_W-1:0] CNT_MAX        = 9'd511;
  localparam logic [LEN_W-1:0] LEN_MAX        = 24'hFF_FFFF;
  localparam logic [CFG_W-1:0] CHAR_COUNT_RST = 9'd256;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_WEIGHT  = 2'd1,
    ACT_COMBINE = 2'd2,
    ACT_FINISH  = 2'd3
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [7:0]          node_index;
    logic [7:0]          first_child;
    logic [7:0]          second_child;
    logic [7:0]          partner_node;
    logic [7:0]          char_index;
    logic [MASK_W-1:0]   state_mask;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] tree_length;
    logic             saturated;
  } out_item_t;

  // Per-word control from the sequencer to the lane unit
  typedef struct packed {
    logic finish;
    logic a_ok;
    logic b_ok;
  } lane_ctl_t;

  // Index width for n entries, at least one bit
  function automatic int idx_w(input int n);
    idx_w = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fpdp_mask_ram.sv =====
// Node state-set store: one word of LANES masks per node and character group.
// One write port with lane enables, two registered read ports. Uses fpdp_pkg.
`default_nettype none
module fpdp_mask_ram
  import fpdp_pkg::*;
#(
  parameter int DEPTH = NODES_DEF,
  parameter int LANES = LANES_DEF
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [idx_w(DEPTH)-1:0]     wr_addr_i,
  input  logic [LANES-1:0]            wr_lane_en_i,
  input  logic [LANES*MASK_W-1:0]     wr_data_i,
  input  logic                        rd_en_i,
  input  logic [idx_w(DEPTH)-1:0]     rd_addr_a_i,
  input  logic [idx_w(DEPTH)-1:0]     rd_addr_b_i,
  output logic [LANES*MASK_W-1:0]     rd_data_a_o,
  output logic [LANES*MASK_W-1:0]     rd_data_b_o
);

  logic [LANES*MASK_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (wr_lane_en_i[l]) begin
          mem_q[wr_addr_i][l*MASK_W +: MASK_W] <= wr_data_i[l*MASK_W +: MASK_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fpdp_char_ram.sv =====
// Per-character weights and change counts, one word of LANES entries per row.
// Separate write ports per store, one shared registered read. Uses fpdp_pkg.
`default_nettype none
module fpdp_char_ram
  import fpdp_pkg::*;
#(
  parameter int WORDS = CHARS_DEF / LANES_DEF,
  parameter int LANES = LANES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [idx_w(WORDS)-1:0]     rd_addr_i,
  output logic [LANES*WEIGHT_W-1:0]   wt_rd_o,
  output logic [LANES*CNT_W-1:0]      cnt_rd_o,
  input  logic                        wt_we_i,
  input  logic [idx_w(WORDS)-1:0]     wt_addr_i,
  input  logic [LANES-1:0]            wt_lane_en_i,
  input  logic [LANES*WEIGHT_W-1:0]   wt_data_i,
  input  logic                        cnt_we_i,
  input  logic [idx_w(WORDS)-1:0]     cnt_addr_i,
  input  logic [LANES*CNT_W-1:0]      cnt_data_i
);

  logic [LANES*WEIGHT_W-1:0] wt_mem_q  [WORDS];
  logic [LANES*CNT_W-1:0]    cnt_mem_q [WORDS];

  always_ff @(posedge clk_i) begin
    if (wt_we_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (wt_lane_en_i[l]) begin
          wt_mem_q[wt_addr_i][l*WEIGHT_W +: WEIGHT_W] <= wt_data_i[l*WEIGHT_W +: WEIGHT_W];
        end
      end
    end
    if (cnt_we_i) begin
      cnt_mem_q[cnt_addr_i] <= cnt_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      wt_rd_o  <= wt_mem_q[rd_addr_i];
      cnt_rd_o <= cnt_mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fpdp_lane_unit.sv =====
// Shared lane unit: Fitch merge, count bump and weighted product per lane,
// with registered group sums. Uses fpdp_pkg.
`default_nettype none
module fpdp_lane_unit
  import fpdp_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic                        clk_i,
  input  lane_ctl_t                   ctl_i,
  input  logic [LANES-1:0]            lane_en_i,
  input  logic [LANES*MASK_W-1:0]     mask_a_i,
  input  logic [LANES*MASK_W-1:0]     mask_b_i,
  input  logic [LANES*CNT_W-1:0]      counts_i,
  input  logic [LANES*WEIGHT_W-1:0]   weights_i,
  output logic [LANES*MASK_W-1:0]     merged_o,
  output logic [LANES*CNT_W-1:0]      counts_o,
  output logic [LEN_W-1:0]            lane_sum_o
);

  localparam int GROUPS = (LANES + GRP_LANES - 1) / GRP_LANES;

  logic [PROD_W-1:0] prod [LANES];
  logic [GRP_W-1:0]  grp_d [GROUPS];
  logic [GRP_W-1:0]  grp_q [GROUPS];

  always_comb begin
    logic [MASK_W-1:0] ma;
    logic [MASK_W-1:0] mb;
    logic [MASK_W-1:0] both;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  bumped;
    logic              chg;
    for (int l = 0; l < LANES; l++) begin
      ma   = ctl_i.a_ok ? mask_a_i[l*MASK_W +: MASK_W] : '0;
      mb   = ctl_i.b_ok ? mask_b_i[l*MASK_W +: MASK_W] : '0;
      both = ma & mb;
      chg  = (both == '0);
      merged_o[l*MASK_W +: MASK_W] = chg ? (ma | mb) : both;
      cnt    = counts_i[l*CNT_W +: CNT_W];
      bumped = (lane_en_i[l] && chg && (cnt != CNT_MAX)) ? cnt + CNT_W'(1) : cnt;
      counts_o[l*CNT_W +: CNT_W] = bumped;
      prod[l] = (ctl_i.finish && lane_en_i[l])
              ? PROD_W'(bumped) * PROD_W'(weights_i[l*WEIGHT_W +: WEIGHT_W])
              : '0;
    end
  end

  // Up to eight products per group
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP_LANES; k++) begin
        if (g*GRP_LANES + k < LANES) begin
          grp_d[g] = grp_d[g] + GRP_W'(prod[g*GRP_LANES + k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    lane_sum_o = '0;
    for (int g = 0; g < GROUPS; g++) begin
      lane_sum_o = lane_sum_o + LEN_W'(grp_q[g]);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fitch_parsimony_down_pass.sv =====
// Top level of the Fitch down-pass block: sequencer, stores and lane unit.
// Uses fpdp_pkg, fpdp_mask_ram, fpdp_char_ram, fpdp_lane_unit and the assert header.
//
// Usage
//   cfg channel : one register, char_count (characters in use, clamped to CHARS);
//                 always ready, write only while the block is idle.
//   in channel  : one item per transfer. Load leaf mask and set weight complete in
//                 the cycle of the transfer. Combine and finish sweep the node store
//                 one word of LANES characters per cycle over WORDS = ceil(CHARS/LANES)
//                 words, and in_ready_o stays low until the sweep and its lane pipeline
//                 have drained (for a finish, also until the result register is free).
//                 The word width of the node store sets the number of words swept.
//   out channel : finish alone gives a result; it sits in an output register until
//                 taken. If the receiver stalls and a second finish completes, that
//                 finish holds in its last state until the register frees up.
//   Reset       : a clearing pass over all WORDS words sets every weight to 1 and every
//                 change count to 0; in_ready_o stays low meanwhile. Node masks are
//                 not cleared and read as undefined until written.
//   Finish sums count * weight per character in a two-stage registered tree and
//   clips the length at 2^24-1, raising saturated.
`default_nettype none
`include "fitch_parsimony_down_pass_assert.svh"
module fitch_parsimony_down_pass
  import fpdp_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int CHARS = CHARS_DEF,
  parameter int LANES = LANES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  localparam int WORDS  = (CHARS + LANES - 1) / LANES;
  localparam int DEPTH  = NODES * WORDS;
  localparam int ADDR_W = idx_w(DEPTH);
  localparam int WORD_W = idx_w(WORDS);
  localparam int LANE_W = idx_w(LANES);
  localparam int CIDX_W = $clog2(WORDS * LANES + 1);
  localparam int CMP_W  = (CIDX_W > CFG_W) ? CIDX_W : CFG_W;

  localparam logic [CMP_W-1:0]  CharsLim  = CMP_W'(CHARS);
  localparam logic [CMP_W-1:0]  LanesStep = CMP_W'(LANES);
  localparam logic [12:0]       NodesLim  = 13'(NODES);
  localparam logic [WORD_W-1:0] WordLast  = WORD_W'(WORDS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  function automatic logic [ADDR_W-1:0] row_of(input logic [7:0] idx);
    row_of = ADDR_W'(ADDR_W'(idx) * ADDR_W'(WORDS));
  endfunction

  function automatic logic node_ok(input logic [7:0] idx);
    node_ok = ({5'b0, idx} < NodesLim);
  endfunction

  // Control state
  state_e              state_q, state_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [CMP_W-1:0]    base_q, base_d;
  logic [CFG_W-1:0]    char_count_q;
  logic                s1_valid_q, s2_valid_q, out_valid_q;

  // Item held for the sweep
  action_e             op_q;
  logic                dst_ok_q, a_ok_q, b_ok_q;
  logic [ADDR_W-1:0]   dst_row_q, a_row_q, b_row_q;
  logic [WORD_W-1:0]   s1_word_q;
  logic [CMP_W-1:0]    s1_base_q;
  logic [LEN_W-1:0]    acc_q;
  logic                sat_q;
  out_item_t           out_data_q;

  logic                in_acc, out_load, is_finish;
  logic [CMP_W-1:0]    n_use;
  logic [WORD_W-1:0]   word_lut [256];
  logic [LANE_W-1:0]   lane_lut [256];
  logic [WORD_W-1:0]   ch_word;
  logic [LANES-1:0]    ch_onehot;
  logic [LANES-1:0]    lane_en;

  logic                    mr_we;
  logic [ADDR_W-1:0]       mr_waddr;
  logic [LANES-1:0]        mr_lane_en;
  logic [LANES*MASK_W-1:0] mr_wdata;
  logic [LANES*MASK_W-1:0] mask_a, mask_b, merged;

  logic                      wt_we, cnt_we;
  logic [WORD_W-1:0]         wt_addr, cnt_addr;
  logic [LANES-1:0]          wt_lane_en;
  logic [LANES*WEIGHT_W-1:0] wt_wdata, wt_rd;
  logic [LANES*CNT_W-1:0]    cnt_wdata, cnt_rd, counts_new;
  logic [LEN_W-1:0]          lane_sum;
  logic [LEN_W:0]            acc_sum;
  lane_ctl_t                 lane_ctl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_finish   = (op_q == ACT_FINISH);

  assign n_use = (CMP_W'(char_count_q) > CharsLim) ? CharsLim : CMP_W'(char_count_q);

  // Character position -> word and lane, worked out at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign word_lut[g] = WORD_W'(g / LANES);
    assign lane_lut[g] = LANE_W'(g % LANES);
  end

  assign ch_word   = word_lut[in_data_i.char_index];
  assign ch_onehot = LANES'(1'b1) << lane_lut[in_data_i.char_index];

  // Lanes of the word in stage 1 that hold characters in use
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_en[l] = ((s1_base_q + CMP_W'(l)) < n_use);
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    word_d   = word_q;
    base_d   = base_q;
    out_load = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        word_d = word_q + WORD_W'(1);
        if (word_q == WordLast) begin
          word_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (in_data_i.action inside {ACT_COMBINE, ACT_FINISH})) begin
          word_d  = '0;
          base_d  = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        word_d = word_q + WORD_W'(1);
        base_d = base_q + LanesStep;
        if (word_q == WordLast) begin
          word_d  = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_q && !s2_valid_q) begin
          if (!is_finish) begin
            state_d = ST_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      word_q       <= '0;
      base_q       <= '0;
      char_count_q <= CHAR_COUNT_RST;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_q     <= word_d;
      base_q     <= base_d;
      s1_valid_q <= (state_q == ST_SWEEP);
      s2_valid_q <= s1_valid_q && is_finish;
      if (cfg_valid_i && cfg_ready_o) begin
        char_count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item fields, stage-1 tags, accumulator and result
  assign acc_sum = {1'b0, acc_q} + {1'b0, lane_sum};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= in_data_i.action;
      dst_ok_q  <= node_ok(in_data_i.node_index);
      dst_row_q <= row_of(in_data_i.node_index);
      if (in_data_i.action == ACT_FINISH) begin
        a_ok_q  <= node_ok(in_data_i.node_index);
        a_row_q <= row_of(in_data_i.node_index);
        b_ok_q  <= node_ok(in_data_i.partner_node);
        b_row_q <= row_of(in_data_i.partner_node);
      end else begin
        a_ok_q  <= node_ok(in_data_i.first_child);
        a_row_q <= row_of(in_data_i.first_child);
        b_ok_q  <= node_ok(in_data_i.second_child);
        b_row_q <= row_of(in_data_i.second_child);
      end
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (s2_valid_q) begin
      acc_q <= acc_sum[LEN_W-1:0];
      sat_q <= sat_q || acc_sum[LEN_W];
    end
    s1_word_q <= word_q;
    s1_base_q <= base_q;
    if (out_load) begin
      out_data_q.tree_length <= sat_q ? LEN_MAX : acc_q;
      out_data_q.saturated   <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Node store write: sweep write-back, else leaf load
  always_comb begin
    if (s1_valid_q) begin
      mr_we      = dst_ok_q;
      mr_waddr   = dst_row_q + ADDR_W'(s1_word_q);
      mr_lane_en = lane_en;
      mr_wdata   = merged;
    end else begin
      mr_we      = in_acc && (in_data_i.action == ACT_LOAD)
                && node_ok(in_data_i.node_index)
                && (CMP_W'(in_data_i.char_index) < CharsLim);
      mr_waddr   = row_of(in_data_i.node_index) + ADDR_W'(ch_word);
      mr_lane_en = ch_onehot;
      mr_wdata   = {LANES{in_data_i.state_mask}};
    end
  end

  // Weight store write: reset fill, else set weight
  always_comb begin
    if (state_q == ST_CLEAR) begin
      wt_we      = 1'b1;
      wt_addr    = word_q;
      wt_lane_en = '1;
      wt_wdata   = {LANES{WEIGHT_W'(1)}};
    end else begin
      wt_we      = in_acc && (in_data_i.action == ACT_WEIGHT)
                && (CMP_W'(in_data_i.char_index) < n_use);
      wt_addr    = ch_word;
      wt_lane_en = ch_onehot;
      wt_wdata   = {LANES{in_data_i.weight}};
    end
  end

  // Count store write: sweep write-back (finish clears), else reset fill
  always_comb begin
    if (s1_valid_q) begin
      cnt_we    = 1'b1;
      cnt_addr  = s1_word_q;
      cnt_wdata = is_finish ? '0 : counts_new;
    end else begin
      cnt_we    = (state_q == ST_CLEAR);
      cnt_addr  = word_q;
      cnt_wdata = '0;
    end
  end

  fpdp_mask_ram #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_mask_ram (
    .clk_i        (clk_i),
    .wr_en_i      (mr_we),
    .wr_addr_i    (mr_waddr),
    .wr_lane_en_i (mr_lane_en),
    .wr_data_i    (mr_wdata),
    .rd_en_i      (state_q == ST_SWEEP),
    .rd_addr_a_i  (a_row_q + ADDR_W'(word_q)),
    .rd_addr_b_i  (b_row_q + ADDR_W'(word_q)),
    .rd_data_a_o  (mask_a),
    .rd_data_b_o  (mask_b)
  );

  fpdp_char_ram #(
    .WORDS (WORDS),
    .LANES (LANES)
  ) u_char_ram (
    .clk_i        (clk_i),
    .rd_en_i      (state_q == ST_SWEEP),
    .rd_addr_i    (word_q),
    .wt_rd_o      (wt_rd),
    .cnt_rd_o     (cnt_rd),
    .wt_we_i      (wt_we),
    .wt_addr_i    (wt_addr),
    .wt_lane_en_i (wt_lane_en),
    .wt_data_i    (wt_wdata),
    .cnt_we_i     (cnt_we),
    .cnt_addr_i   (cnt_addr),
    .cnt_data_i   (cnt_wdata)
  );

  assign lane_ctl = '{finish: is_finish, a_ok: a_ok_q, b_ok: b_ok_q};

  fpdp_lane_unit #(
    .LANES (LANES)
  ) u_lane_unit (
    .clk_i      (clk_i),
    .ctl_i      (lane_ctl),
    .lane_en_i  (lane_en),
    .mask_a_i   (mask_a),
    .mask_b_i   (mask_b),
    .counts_i   (cnt_rd),
    .weights_i  (wt_rd),
    .merged_o   (merged),
    .counts_o   (counts_new),
    .lane_sum_o (lane_sum)
  );

  // Checks
  `FPDP_ASSERT(a_ready_only_drained, clk_i, rst_ni, in_ready_o |-> (!s1_valid_q && !s2_valid_q), "input ready while lane pipeline busy")
  `FPDP_ASSERT(a_result_from_finish, clk_i, rst_ni, out_load |-> is_finish, "result loaded for an item other than finish")
  `FPDP_ASSERT(a_result_not_lost, clk_i, rst_ni, out_load |-> (!out_valid_q || out_ready_i), "result register overwritten while held")
  `FPDP_ASSERT_NEVER(a_sweep_in_clear, clk_i, rst_ni, s1_valid_q && (state_q == ST_CLEAR), "sweep write-back during reset fill")

endmodule
`default_nettype wire
